// ===== src/bprp_pkg.sv =====
// Shared types and constants for the bad pixel run painter.
// Request, response and configuration structs, and the code enums.
// Depends on nothing; the design files refer to it by scoped names, the testbench imports it.
package bprp_pkg;

   localparam int FLAG_W  = 16;
   localparam int POS_W   = 11;   // image sizes are 11-bit registers
   localparam int CNT_W   = 11;
   localparam int COORD_W = 17;   // signed run coordinates before clipping

   typedef enum logic [1:0] {
      REQ_RUN   = 2'd0,
      REQ_READ  = 2'd1,
      REQ_WRITE = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      OUT_DONE        = 2'd0,
      OUT_SKIPPED     = 2'd1,
      OUT_BAD_LENGTH  = 2'd2,
      OUT_BAD_ADDRESS = 2'd3
   } outcome_type;

   typedef enum logic [2:0] {
      CSR_IMAGE_WIDTH    = 3'd0,
      CSR_IMAGE_HEIGHT   = 3'd1,
      CSR_OFFSET_X       = 3'd2,
      CSR_OFFSET_Y       = 3'd3,
      CSR_SHIFT_ENABLE   = 3'd4,
      CSR_SPLIT_COLUMN   = 3'd5,
      CSR_OVERSCAN_SHIFT = 3'd6
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_CLIP,
      ST_RUN,
      ST_DRAIN,
      ST_READ
   } state_type;

   typedef struct packed {
      req_kind_type        req_type;
      logic [13:0]         table_x;
      logic [13:0]         table_y;
      logic [13:0]         run_length;
      logic                along_y;
      logic [FLAG_W-1:0]   flag_value;
      logic [9:0]          pixel_x;
      logic [9:0]          pixel_y;
      logic [FLAG_W-1:0]   pixel_value;
   } request_type;

   typedef struct packed {
      logic [FLAG_W-1:0]   read_value;
      outcome_type         outcome;
      logic [CNT_W-1:0]    pixels_flagged;
   } response_type;

   typedef struct packed {
      logic [10:0]         image_width;
      logic [10:0]         image_height;
      logic signed [14:0]  offset_x;
      logic signed [14:0]  offset_y;
      logic                shift_enable;
      logic [13:0]         split_column;
      logic [10:0]         overscan_shift;
   } cfg_type;

endpackage

// ===== src/bprp_store.sv =====
// Flag word memory with a registered read port and one write port.
// After reset a sweep writes zero to every entry before the store is used.
// Depends on bprp_pkg for the flag word width.
module bprp_store #(
   parameter int ADDR_W = 20
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [bprp_pkg::FLAG_W-1:0] rd_data,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [bprp_pkg::FLAG_W-1:0] wr_data,
   output logic                        clear_busy
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [bprp_pkg::FLAG_W-1:0] mem_ff [DEPTH];
   logic [bprp_pkg::FLAG_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0]           clr_addr_ff, clr_addr_in;
   logic                        clr_busy_ff, clr_busy_in;

   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == {ADDR_W{1'b1}}) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem_ff[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = clr_busy_ff;

endmodule

// ===== src/bprp_ctrl.sv =====
// Request sequencer: maps and clips runs, then walks the run one pixel a
// cycle with a pipelined read-modify-write on the flag store.
// Depends on bprp_pkg for request, response, configuration and state types.
module bprp_ctrl #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  bprp_pkg::request_type       req_data,
   output logic                        busy,
   output logic                        rsp_valid,
   output bprp_pkg::response_type      rsp_data,
   input  bprp_pkg::cfg_type           cfg,
   input  logic                        clear_busy,
   output logic                        rd_en,
   output logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)-1:0] rd_addr,
   input  logic [bprp_pkg::FLAG_W-1:0] rd_data,
   output logic                        wr_en,
   output logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)-1:0] wr_addr,
   output logic [bprp_pkg::FLAG_W-1:0] wr_data
);

   localparam int XW     = $clog2(MAX_WIDTH);
   localparam int YW     = $clog2(MAX_HEIGHT);
   localparam int AW     = XW + YW;
   localparam int PW     = bprp_pkg::POS_W;
   localparam int CW     = bprp_pkg::COORD_W;

   bprp_pkg::state_type     state_ff, state_in;
   bprp_pkg::request_type   req_ff, req_in;
   bprp_pkg::response_type  rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [CW-1:0]    xs_ff, xs_in, ys_ff, ys_in;
   logic [PW-1:0]           pos_ff, pos_in, end_ff, end_in, fixed_ff, fixed_in;
   logic [bprp_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                    pend_ff, pend_in;
   logic [AW-1:0]           pend_addr_ff, pend_addr_in;

   logic [PW-1:0]           used_w, used_h, run_x, run_y, px, py;
   logic signed [CW-1:0]    tx_s, ty_s, split_s, shift_s, len_s, xs_base;
   logic signed [CW-1:0]    lo, hi, fixd, lim_run, lim_fix, lo_c, hi_c;
   logic                    skip;
   logic [AW-1:0]           run_addr, pix_addr;

   // Image sizes larger than the store are clamped to it.
   always_comb begin
      used_w = (32'(cfg.image_width) > MAX_WIDTH) ? PW'(MAX_WIDTH) : cfg.image_width;
      used_h = (32'(cfg.image_height) > MAX_HEIGHT) ? PW'(MAX_HEIGHT) : cfg.image_height;
   end

   // Start mapping: one-indexed to zero-indexed, overscan shift, offsets.
   always_comb begin
      tx_s    = CW'(req_ff.table_x);
      ty_s    = CW'(req_ff.table_y);
      split_s = CW'(cfg.split_column);
      shift_s = CW'(cfg.overscan_shift);
      xs_base = tx_s - CW'(1);
      if (cfg.shift_enable && (xs_base >= split_s)) begin
         xs_in = xs_base + shift_s + CW'(cfg.offset_x);
      end else begin
         xs_in = xs_base + CW'(cfg.offset_x);
      end
      ys_in = ty_s - CW'(1) + CW'(cfg.offset_y);
   end

   // Clipping of the mapped run against the image.
   always_comb begin
      len_s = CW'(req_ff.run_length);
      if (req_ff.along_y) begin
         lo      = ys_ff;
         fixd    = xs_ff;
         lim_run = CW'(used_h);
         lim_fix = CW'(used_w);
      end else begin
         lo      = xs_ff;
         fixd    = ys_ff;
         lim_run = CW'(used_w);
         lim_fix = CW'(used_h);
      end
      hi   = lo + len_s - CW'(1);
      skip = (hi < 0) || (lo >= lim_run) || (fixd < 0) || (fixd >= lim_fix);
      lo_c = (lo < 0) ? '0 : lo;
      hi_c = (hi >= lim_run) ? (lim_run - CW'(1)) : hi;
   end

   always_comb begin
      if (req_ff.along_y) begin
         run_x = fixed_ff;
         run_y = pos_ff;
      end else begin
         run_x = pos_ff;
         run_y = fixed_ff;
      end
      px       = PW'(req_ff.pixel_x);
      py       = PW'(req_ff.pixel_y);
      run_addr = {YW'(run_y), XW'(run_x)};
      pix_addr = {YW'(py), XW'(px)};
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = '0;
      pos_in        = pos_ff;
      end_in        = end_ff;
      fixed_in      = fixed_ff;
      cnt_in        = cnt_ff;
      pend_in       = 1'b0;
      pend_addr_in  = pend_addr_ff;
      rd_en         = 1'b0;
      rd_addr       = pix_addr;
      // A pixel read in the previous cycle gets its flag ORed in and goes back.
      wr_en         = pend_ff;
      wr_addr       = pend_addr_ff;
      wr_data       = rd_data | req_ff.flag_value;

      case (state_ff)
         bprp_pkg::ST_CLEAR: begin
            if (!clear_busy) begin
               state_in = bprp_pkg::ST_IDLE;
            end
         end
         bprp_pkg::ST_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = bprp_pkg::ST_DECODE;
            end
         end
         bprp_pkg::ST_DECODE: begin
            case (req_ff.req_type)
               bprp_pkg::REQ_RUN: begin
                  if (req_ff.run_length == '0) begin
                     rsp_valid_in   = 1'b1;
                     rsp_in.outcome = bprp_pkg::OUT_BAD_LENGTH;
                     state_in       = bprp_pkg::ST_IDLE;
                  end else begin
                     state_in = bprp_pkg::ST_CLIP;
                  end
               end
               bprp_pkg::REQ_READ, bprp_pkg::REQ_WRITE: begin
                  if ((px >= used_w) || (py >= used_h)) begin
                     rsp_valid_in   = 1'b1;
                     rsp_in.outcome = bprp_pkg::OUT_BAD_ADDRESS;
                     state_in       = bprp_pkg::ST_IDLE;
                  end else if (req_ff.req_type == bprp_pkg::REQ_READ) begin
                     rd_en    = 1'b1;
                     state_in = bprp_pkg::ST_READ;
                  end else begin
                     wr_en          = 1'b1;
                     wr_addr        = pix_addr;
                     wr_data        = req_ff.pixel_value;
                     rsp_valid_in   = 1'b1;
                     rsp_in.outcome = bprp_pkg::OUT_DONE;
                     state_in       = bprp_pkg::ST_IDLE;
                  end
               end
               default: begin
                  rsp_valid_in   = 1'b1;
                  rsp_in.outcome = bprp_pkg::OUT_BAD_ADDRESS;
                  state_in       = bprp_pkg::ST_IDLE;
               end
            endcase
         end
         bprp_pkg::ST_CLIP: begin
            if (skip) begin
               rsp_valid_in   = 1'b1;
               rsp_in.outcome = bprp_pkg::OUT_SKIPPED;
               state_in       = bprp_pkg::ST_IDLE;
            end else begin
               pos_in   = PW'(lo_c);
               end_in   = PW'(hi_c);
               fixed_in = PW'(fixd);
               cnt_in   = '0;
               state_in = bprp_pkg::ST_RUN;
            end
         end
         bprp_pkg::ST_RUN: begin
            rd_en        = 1'b1;
            rd_addr      = run_addr;
            pend_in      = 1'b1;
            pend_addr_in = run_addr;
            pos_in       = pos_ff + PW'(1);
            cnt_in       = cnt_ff + bprp_pkg::CNT_W'(1);
            if (pos_ff == end_ff) begin
               state_in = bprp_pkg::ST_DRAIN;
            end
         end
         bprp_pkg::ST_DRAIN: begin
            rsp_valid_in          = 1'b1;
            rsp_in.outcome        = bprp_pkg::OUT_DONE;
            rsp_in.pixels_flagged = cnt_ff;
            state_in              = bprp_pkg::ST_IDLE;
         end
         bprp_pkg::ST_READ: begin
            rsp_valid_in      = 1'b1;
            rsp_in.outcome    = bprp_pkg::OUT_DONE;
            rsp_in.read_value = rd_data;
            state_in          = bprp_pkg::ST_IDLE;
         end
         default: begin
            state_in = bprp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bprp_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      rsp_ff       <= rsp_in;
      xs_ff        <= xs_in;
      ys_ff        <= ys_in;
      pos_ff       <= pos_in;
      end_ff       <= end_in;
      fixed_ff     <= fixed_in;
      cnt_ff       <= cnt_in;
      pend_addr_ff <= pend_addr_in;
   end

   assign busy      = (state_ff != bprp_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== src/bad_pixel_run_painter_unit.sv =====
// Top level of the bad pixel run painter: configuration registers and the
// connection of the request sequencer to the flag store.
// Depends on bprp_pkg, bprp_store and bprp_ctrl.
//
//   channel   ports                               transfer when
//   --------  ----------------------------------  ---------------------------
//   request   start, busy, req_data               start high and busy low
//   response  rsp_valid, rsp_data                 rsp_valid high (one cycle)
//   config    csr_valid, csr_ready, csr_index,    csr_valid and csr_ready high
//             csr_wdata
//
// A run passes the decode, clip, run and drain states after its transfer; the walk
// reads and writes back one store entry a cycle. A read passes decode and read, a
// skipped run decode and clip; a write, a zero length or a rejected address ends in
// decode. The response strobe follows the last busy cycle.
// After reset the store is zeroed one entry a cycle, all 2**(clog2(MAX_WIDTH) +
// clog2(MAX_HEIGHT)) entries, with busy high throughout.
// The response cannot be stalled; configuration writes are always taken.
module bad_pixel_run_painter_unit #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  bprp_pkg::request_type  req_data,
   output logic                   rsp_valid,
   output bprp_pkg::response_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [2:0]             csr_index,
   input  logic [15:0]            csr_wdata
);

   localparam int AW = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT);

   bprp_pkg::cfg_type           cfg_ff, cfg_in;
   logic                        clear_busy;
   logic                        rd_en, wr_en;
   logic [AW-1:0]               rd_addr, wr_addr;
   logic [bprp_pkg::FLAG_W-1:0] rd_data, wr_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (bprp_pkg::csr_reg_type'(csr_index))
            bprp_pkg::CSR_IMAGE_WIDTH:    cfg_in.image_width    = csr_wdata[10:0];
            bprp_pkg::CSR_IMAGE_HEIGHT:   cfg_in.image_height   = csr_wdata[10:0];
            bprp_pkg::CSR_OFFSET_X:       cfg_in.offset_x       = csr_wdata[14:0];
            bprp_pkg::CSR_OFFSET_Y:       cfg_in.offset_y       = csr_wdata[14:0];
            bprp_pkg::CSR_SHIFT_ENABLE:   cfg_in.shift_enable   = csr_wdata[0];
            bprp_pkg::CSR_SPLIT_COLUMN:   cfg_in.split_column   = csr_wdata[13:0];
            bprp_pkg::CSR_OVERSCAN_SHIFT: cfg_in.overscan_shift = csr_wdata[10:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width    <= 11'd1024;
         cfg_ff.image_height   <= 11'd1024;
         cfg_ff.offset_x       <= '0;
         cfg_ff.offset_y       <= '0;
         cfg_ff.shift_enable   <= 1'b0;
         cfg_ff.split_column   <= '0;
         cfg_ff.overscan_shift <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bprp_store #(
      .ADDR_W (AW)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .clear_busy (clear_busy)
   );

   bprp_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .cfg        (cfg_ff),
      .clear_busy (clear_busy),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data)
   );

endmodule

// ===== tb/tb_bad_pixel_run_painter_unit.sv =====
// Self-checking testbench for bad_pixel_run_painter_unit: flag runs, pixel reads and writes.
// Predicts every response from its own copy of the flag store and registers.
// Depends on bprp_pkg and the block's top level, with its store and sequencer.
module tb_bad_pixel_run_painter_unit;
   import bprp_pkg::*;

   localparam int STORE_W = 1024;
   localparam int STORE_H = 1024;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   request_type  req_data = '0;
   logic         rsp_valid;
   response_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index = '0;
   logic [15:0]  csr_wdata = '0;

   bad_pixel_run_painter_unit #(
      .MAX_WIDTH (STORE_W),
      .MAX_HEIGHT(STORE_H)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // Predicted flag image and register copies, at their reset values.
   bit [15:0] flag_mem [STORE_W*STORE_H];
   int cfg_width    = 1024;
   int cfg_height   = 1024;
   int cfg_off_x    = 0;
   int cfg_off_y    = 0;
   int cfg_shift    = 0;
   int cfg_split    = 0;
   int cfg_overscan = 0;

   request_type  pending_req[$];
   response_type expected_rsp[$];
   int           idle_pct = 19;
   int           mismatch_count = 0;

   function automatic void set_cfg(csr_reg_type idx, logic [15:0] v);
      case (idx)
         CSR_IMAGE_WIDTH:    cfg_width    = v[10:0];
         CSR_IMAGE_HEIGHT:   cfg_height   = v[10:0];
         CSR_OFFSET_X:       cfg_off_x    = $signed(v[14:0]);
         CSR_OFFSET_Y:       cfg_off_y    = $signed(v[14:0]);
         CSR_SHIFT_ENABLE:   cfg_shift    = v[0];
         CSR_SPLIT_COLUMN:   cfg_split    = v[13:0];
         CSR_OVERSCAN_SHIFT: cfg_overscan = v[10:0];
         default: ;
      endcase
   endfunction

   function automatic int used_width();
      return (cfg_width > STORE_W) ? STORE_W : cfg_width;
   endfunction

   function automatic int used_height();
      return (cfg_height > STORE_H) ? STORE_H : cfg_height;
   endfunction

   // Applies one request to the predicted image and returns its response.
   function automatic response_type paint_and_predict(request_type r);
      response_type res;
      int w, h, xs, ys, len, lo, hi, fixd;
      bit skip;
      res = '0;
      w = used_width();
      h = used_height();
      if (r.req_type == REQ_RUN) begin
         len = r.run_length;
         if (len == 0) begin
            res.outcome = OUT_BAD_LENGTH;
         end else begin
            xs = int'(r.table_x) - 1;
            ys = int'(r.table_y) - 1;
            if (cfg_shift != 0 && xs >= cfg_split)
               xs += cfg_overscan;
            xs += cfg_off_x;
            ys += cfg_off_y;
            if (!r.along_y) begin
               lo = xs;
               fixd = ys;
               skip = (fixd < 0 || fixd >= h);
            end else begin
               lo = ys;
               fixd = xs;
               skip = (fixd < 0 || fixd >= w);
               w = h;
            end
            // From here w is the extent of the axis along which the run goes.
            hi = lo + len - 1;
            if (skip || hi < 0 || lo >= w) begin
               res.outcome = OUT_SKIPPED;
            end else begin
               if (lo < 0) lo = 0;
               if (hi >= w) hi = w - 1;
               for (int k = lo; k <= hi; k++) begin
                  if (!r.along_y)
                     flag_mem[fixd*STORE_W + k] |= r.flag_value;
                  else
                     flag_mem[k*STORE_W + fixd] |= r.flag_value;
               end
               res.outcome = OUT_DONE;
               res.pixels_flagged = 11'(hi - lo + 1);
            end
         end
      end else if (r.req_type == REQ_READ || r.req_type == REQ_WRITE) begin
         if (int'(r.pixel_x) >= w || int'(r.pixel_y) >= h) begin
            res.outcome = OUT_BAD_ADDRESS;
         end else begin
            res.outcome = OUT_DONE;
            if (r.req_type == REQ_READ)
               res.read_value = flag_mem[r.pixel_y*STORE_W + r.pixel_x];
            else
               flag_mem[r.pixel_y*STORE_W + r.pixel_x] = r.pixel_value;
         end
      end else begin
         res.outcome = OUT_BAD_ADDRESS;
      end
      return res;
   endfunction

   // Request driver: a request transfers when start is high and busy is low.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy)
            expected_rsp.push_back(paint_and_predict(req_data));
         if (!start || !busy) begin
            if (pending_req.size() != 0 && $urandom_range(99) >= idle_pct) begin
               req_data <= pending_req.pop_front();
               start    <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Response monitor: every strobed response is checked against the oldest prediction.
   always @(posedge clock) begin : rsp_monitor
      response_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsp.size() == 0) begin
            $error("unexpected response: read_value %h outcome %0d pixels_flagged %0d",
                   rsp_data.read_value, rsp_data.outcome, rsp_data.pixels_flagged);
            mismatch_count++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.read_value !== want.read_value) begin
               $error("read_value: expected %h, got %h", want.read_value,
                      rsp_data.read_value);
               mismatch_count++;
            end
            if (rsp_data.outcome !== want.outcome) begin
               $error("outcome: expected %0d, got %0d", want.outcome, rsp_data.outcome);
               mismatch_count++;
            end
            if (rsp_data.pixels_flagged !== want.pixels_flagged) begin
               $error("pixels_flagged: expected %0d, got %0d", want.pixels_flagged,
                      rsp_data.pixels_flagged);
               mismatch_count++;
            end
         end
      end
   end

   function automatic request_type random_fields();
      request_type r;
      r.req_type    = REQ_RUN;
      r.table_x     = 14'($urandom_range(8192));
      r.table_y     = 14'($urandom_range(8192));
      r.run_length  = 14'($urandom_range(8192));
      r.along_y     = 1'($urandom_range(1));
      r.flag_value  = 16'($urandom);
      r.pixel_x     = 10'($urandom);
      r.pixel_y     = 10'($urandom);
      r.pixel_value = 16'($urandom);
      return r;
   endfunction

   function automatic request_type make_run(int tx, int ty, int len, bit along,
                                            logic [15:0] flag);
      request_type r;
      r = random_fields();
      r.table_x    = 14'(tx);
      r.table_y    = 14'(ty);
      r.run_length = 14'(len);
      r.along_y    = along;
      r.flag_value = flag;
      return r;
   endfunction

   function automatic request_type make_pixel(req_kind_type kind, int px, int py,
                                              logic [15:0] val);
      request_type r;
      r = random_fields();
      r.req_type    = kind;
      r.pixel_x     = 10'(px);
      r.pixel_y     = 10'(py);
      r.pixel_value = val;
      return r;
   endfunction

   function automatic logic [13:0] table_coord(int v);
      if (v < 1) return 14'd1;
      if (v > 8192) return 14'd8192;
      return 14'(v);
   endfunction

   // Mostly well-formed requests aimed at a small corner of the image so that
   // runs, writes and reads keep landing on the same pixels.
   function automatic request_type random_request();
      request_type r;
      int sel, span_w, span_h, px, py, xs0, ys0, len, pick;
      r = random_fields();
      sel = $urandom_range(99);
      span_w = (used_width() < 1) ? 1 : (used_width() > 48 ? 48 : used_width());
      span_h = (used_height() < 1) ? 1 : (used_height() > 48 ? 48 : used_height());
      px = $urandom_range(span_w - 1);
      py = $urandom_range(span_h - 1);
      if ($urandom_range(9) == 0) begin
         px = $urandom_range(1023);
         py = $urandom_range(1023);
      end
      if (sel < 55) begin
         pick = $urandom_range(19);
         if (pick < 14)
            len = $urandom_range(16, 1);
         else if (pick < 19)
            len = $urandom_range(300, 17);
         else
            len = $urandom_range(8192, 301);
         r.req_type = REQ_RUN;
         r.run_length = 14'(len);
         if (r.along_y)
            py -= $urandom_range(4);
         else
            px -= $urandom_range(4);
         xs0 = px - cfg_off_x;
         if (cfg_shift != 0 && xs0 - cfg_overscan >= cfg_split)
            xs0 -= cfg_overscan;
         ys0 = py - cfg_off_y;
         r.table_x = table_coord(xs0 + 1);
         r.table_y = table_coord(ys0 + 1);
      end else if (sel < 75) begin
         r = make_pixel(REQ_READ, px, py, 16'($urandom));
      end else if (sel < 92) begin
         r = make_pixel(REQ_WRITE, px, py, 16'($urandom));
      end else if (sel < 96) begin
         r.run_length = '0;
      end else if (sel < 98) begin
         r.req_type = req_kind_type'(REQ_UNUSED);
      end else begin
         r.req_type = req_kind_type'(2'($urandom_range(3)));
      end
      return r;
   endfunction

   // Waits, sampling between edges, until no request is queued or in flight.
   task automatic wait_quiet();
      do
         @(negedge clock);
      while (pending_req.size() != 0 || start || busy !== 1'b0 ||
             expected_rsp.size() != 0);
   endtask

   task automatic write_reg(csr_reg_type idx, int val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 16'(val);
      do
         @(posedge clock);
      while (!csr_ready);
      set_cfg(idx, 16'(val));
      csr_valid <= 1'b0;
   endtask

   task automatic program_regs(int w, int h, int ox, int oy, int se, int sp, int os);
      wait_quiet();
      write_reg(CSR_IMAGE_WIDTH, w);
      write_reg(CSR_IMAGE_HEIGHT, h);
      write_reg(CSR_OFFSET_X, ox);
      write_reg(CSR_OFFSET_Y, oy);
      write_reg(CSR_SHIFT_ENABLE, se);
      write_reg(CSR_SPLIT_COLUMN, sp);
      write_reg(CSR_OVERSCAN_SHIFT, os);
   endtask

   task automatic queue_random(int n);
      repeat (n) pending_req.push_back(random_request());
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset configuration: the store must read back cleared first.
      pending_req.push_back(make_pixel(REQ_READ, 0, 0, 16'h0000));
      pending_req.push_back(make_pixel(REQ_WRITE, 0, 0, 16'hFFFF));
      pending_req.push_back(make_pixel(REQ_READ, 0, 0, 16'h0000));
      pending_req.push_back(make_pixel(REQ_WRITE, 1023, 1023, 16'h8001));
      pending_req.push_back(make_pixel(REQ_READ, 1023, 1023, 16'h0000));
      pending_req.push_back(make_pixel(REQ_READ, 1023, 0, 16'hFFFF));
      pending_req.push_back(make_run(1, 2, 1, 1'b0, 16'h0001));
      // A table start of zero begins the run one pixel before the image.
      pending_req.push_back(make_run(0, 2, 3, 1'b0, 16'h0002));
      pending_req.push_back(make_run(1, 0, 4, 1'b1, 16'h0004));
      pending_req.push_back(make_pixel(REQ_READ, 0, 1, 16'h0000));
      pending_req.push_back(make_run(5, 5, 0, 1'b0, 16'hFFFF));
      pending_req.push_back(make_run(1, 11, 8192, 1'b0, 16'h0010));
      pending_req.push_back(make_run(8192, 5, 5, 1'b0, 16'h0020));
      pending_req.push_back(make_run(1024, 1, 8192, 1'b1, 16'h2000));
      pending_req.push_back(make_run(8191, 8192, 7, 1'b1, 16'h0100));
      pending_req.push_back(make_pixel(REQ_READ, 1023, 1023, 16'h0000));
      pending_req.push_back(make_pixel(req_kind_type'(REQ_UNUSED), 3, 3, 16'h1234));
      pending_req.push_back(make_pixel(REQ_WRITE, 5, 10, 16'h0000));
      pending_req.push_back(make_pixel(REQ_READ, 5, 10, 16'h0000));
      pending_req.push_back(make_run(1000, 20, 50, 1'b0, 16'h4000));
      queue_random(150);

      // Four-amp shift: start columns from the split onward move right.
      program_regs(1024, 1024, 0, 0, 1, 100, 24);
      idle_pct = 0;
      pending_req.push_back(make_run(101, 1, 1, 1'b0, 16'h0040));
      pending_req.push_back(make_run(100, 1, 1, 1'b0, 16'h0080));
      pending_req.push_back(make_pixel(REQ_READ, 124, 0, 16'h0000));
      pending_req.push_back(make_pixel(REQ_READ, 99, 0, 16'h0000));
      pending_req.push_back(make_pixel(REQ_READ, 100, 0, 16'h0000));
      queue_random(300);

      // Split at zero: a start of minus one still escapes the shift.
      program_regs(1024, 1024, 0, 0, 1, 0, 1024);
      idle_pct = 19;
      pending_req.push_back(make_run(0, 1, 3, 1'b0, 16'h0200));
      pending_req.push_back(make_run(1, 1, 3, 1'b0, 16'h0400));
      queue_random(40);

      program_regs(1, 1, -8192, 8192, 0, 8192, 0);
      queue_random(40);

      // An empty image rejects everything.
      program_regs(0, 0, 0, 0, 0, 0, 0);
      queue_random(30);

      // Sizes beyond the store are clamped to it.
      program_regs(2047, 1500, 8192, -8192, 1, 8192, 1023);
      queue_random(40);

      repeat (4) begin
         program_regs(($urandom_range(1) != 0) ? $urandom_range(64, 1) : $urandom_range(1024, 1),
                      ($urandom_range(1) != 0) ? $urandom_range(64, 1) : $urandom_range(1024, 1),
                      int'($urandom_range(400)) - 200, int'($urandom_range(400)) - 200,
                      $urandom_range(1), $urandom_range(300), $urandom_range(64));
         queue_random(140);
      end

      wait_quiet();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && expected_rsp.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // The store clears every entry after reset; allow for that
   // and for every request taking its longest possible run several times over.
   initial begin
      #200_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
